// ===== rtl/bfom_pkg.sv =====
// Shared types and constants for the folding op machine.
// Used by bfom_front, bfom_exec and the top level; depends on nothing.
package bfom_pkg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] prog_char;
        logic [7:0] in_byte;
        logic       in_valid;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       in_taken;
        logic       halted;
        logic [2:0] status;
    } res_item_t;

    localparam logic [1:0] CODE_CLEAR  = 2'd0;
    localparam logic [1:0] CODE_LOAD   = 2'd1;
    localparam logic [1:0] CODE_FINISH = 2'd2;
    localparam logic [1:0] CODE_STEP   = 2'd3;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_LOAD,
        CMD_FINISH,
        CMD_STEP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        cmd_item_t item;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

    typedef enum logic [2:0] {
        OP_END,
        OP_SET,
        OP_ADD,
        OP_PTR,
        OP_PRINT,
        OP_READ,
        OP_OPEN,
        OP_CLOSE
    } op_type_t;

    typedef struct packed {
        op_type_t    kind;
        logic [15:0] data;
    } op_t;

    typedef enum logic [2:0] {
        PH_LOADING,
        PH_READY,
        PH_HALTED,
        PH_FULL,
        PH_UNBAL,
        PH_DEEP
    } phase_t;

    typedef enum logic [1:0] {
        LA_NONE,
        LA_OPEN,
        LA_OPEN_MINUS
    } look_t;

    typedef enum logic [3:0] {
        EX_CLR_INIT,
        EX_IDLE,
        EX_EMIT,
        EX_CLOSE_RD,
        EX_CLOSE_WR,
        EX_FIN,
        EX_CLR_FIN,
        EX_FETCH,
        EX_EXEC,
        EX_DONE
    } exec_state_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_UNBAL  = 3'd2;
    localparam logic [2:0] ST_DEEP   = 3'd3;
    localparam logic [2:0] ST_EARLY  = 3'd4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

endpackage

// ===== rtl/bfom_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module bfom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bfom_front.sv =====
// Front end: accepts command transfers, classifies them and queues them.
// Depends on bfom_pkg.
module bfom_front
    import bfom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_item_t   cmd_item,
    output queue_head_t head,
    input  logic        pop
);

    queue_entry_t q_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    cmd_kind_t    kind;
    logic         push;

    always_comb
    begin
        case (cmd_item.command)
            CODE_CLEAR:  kind = CMD_CLEAR;
            CODE_LOAD:   kind = CMD_LOAD;
            CODE_FINISH: kind = CMD_FINISH;
            CODE_STEP:   kind = CMD_STEP;
            default:     kind = CMD_STEP;
        endcase
    end

    assign cmd_stall = (count_reg == 2'd2);
    assign push      = cmd_valid && !cmd_stall;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{kind: kind, item: cmd_item};
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.entry = q_reg[rd_ptr_reg];

endmodule

// ===== rtl/bfom_exec.sv =====
// Back end: compiles characters into folded ops and executes them.
// Depends on bfom_pkg and bfom_ram.
module bfom_exec
    import bfom_pkg::*;
#(
    parameter int PROG_OPS   = 4096,
    parameter int TAPE_CELLS = 32768,
    parameter int NEST_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    output logic        res_valid,
    input  logic        res_stall,
    output res_item_t   res_item
);

    localparam int PW  = $clog2(PROG_OPS);
    localparam int CW  = PW + 1;
    localparam int TW  = $clog2(TAPE_CELLS);
    localparam int SW  = $clog2(NEST_DEPTH);
    localparam int SDW = SW + 1;
    localparam logic [CW-1:0]  OPS_LAST  = CW'(PROG_OPS - 1);
    localparam logic [CW-1:0]  OPS_CNT   = CW'(PROG_OPS);
    localparam logic [16:0]    OPS_SPAN  = 17'(PROG_OPS);
    localparam logic [16:0]    TAPE_SPAN = 17'(TAPE_CELLS);
    localparam logic [15:0]    PTR_BACK  = 16'(TAPE_CELLS - 1);
    localparam logic [TW-1:0]  TAPE_END  = TW'(TAPE_CELLS - 1);
    localparam logic [SDW-1:0] STACK_CAP = SDW'(NEST_DEPTH);

    exec_state_t    state_reg, state_next;
    phase_t         phase_reg, phase_next;
    look_t          la_reg, la_next;
    logic [CW-1:0]  op_count_reg, op_count_next;
    logic [SDW-1:0] stack_top_reg, stack_top_next;
    logic [PW-1:0]  pc_reg, pc_next;
    logic [TW-1:0]  cp_reg, cp_next;
    logic [TW-1:0]  clr_addr_reg, clr_addr_next;
    logic [1:0]     em_n_reg, em_n_next;
    logic [1:0]     em_i_reg, em_i_next;
    logic           out_full_reg, out_full_next;

    op_type_t       em_kind_reg [3];
    op_type_t       em_kind_next [3];
    logic [15:0]    em_data_reg [3];
    logic [15:0]    em_data_next [3];
    op_t            last_reg, last_next;
    logic [PW-1:0]  open_reg, open_next;
    logic [7:0]     r_byte_reg, r_byte_next;
    logic           r_ov_reg, r_ov_next;
    logic           r_taken_reg, r_taken_next;
    logic           r_early_reg, r_early_next;
    res_item_t      out_item_reg, out_item_next;

    logic           st_we;
    logic [PW-1:0]  st_waddr, st_raddr;
    op_t            st_wdata;
    logic [18:0]    st_rdata;
    logic           tp_we;
    logic [TW-1:0]  tp_waddr, tp_raddr;
    logic [7:0]     tp_wdata, tp_rdata;
    logic           sk_we;
    logic [SW-1:0]  sk_waddr, sk_raddr;
    logic [PW-1:0]  sk_wdata, sk_rdata;

    cmd_kind_t      kind;
    logic [7:0]     ch;
    op_type_t       cur_kind;
    logic [15:0]    cur_data;
    logic           em_left, em_live, has_prev, merge_add, merge_ptr, no_room, close_go;
    logic [16:0]    ptr_sum, ptr_wrap, cp_sum, cp_wrap, tgt_sum;
    logic [CW-1:0]  pc_sum;
    logic [PW-1:0]  pc_inc, open_tgt;
    logic [1:0]     fill_n;
    logic           out_free, clr_last;
    op_t            exec_op;
    logic [2:0]     status;

    bfom_ram #(.WIDTH(19), .DEPTH(PROG_OPS)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    bfom_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
        .clk(clk), .we(tp_we), .waddr(tp_waddr), .wdata(tp_wdata),
        .raddr(tp_raddr), .rdata(tp_rdata)
    );

    bfom_ram #(.WIDTH(PW), .DEPTH(NEST_DEPTH)) u_stack (
        .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .raddr(sk_raddr), .rdata(sk_rdata)
    );

    assign kind      = head.entry.kind;
    assign ch        = head.entry.item.prog_char;
    assign cur_kind  = em_kind_reg[em_i_reg];
    assign cur_data  = em_data_reg[em_i_reg];
    assign em_left   = (em_i_reg != em_n_reg);
    assign em_live   = em_left && (phase_reg == PH_LOADING);
    assign has_prev  = (op_count_reg != '0);
    assign merge_add = has_prev && (cur_kind == OP_ADD)
                       && ((last_reg.kind == OP_SET) || (last_reg.kind == OP_ADD));
    assign merge_ptr = has_prev && (cur_kind == OP_PTR) && (last_reg.kind == OP_PTR);
    assign no_room   = (op_count_reg >= OPS_LAST);
    assign close_go  = em_live && !merge_add && !merge_ptr && !no_room
                       && (cur_kind == OP_CLOSE) && (stack_top_reg != '0);

    assign ptr_sum   = {1'b0, last_reg.data} + {1'b0, cur_data};
    assign ptr_wrap  = (ptr_sum >= TAPE_SPAN) ? (ptr_sum - TAPE_SPAN) : ptr_sum;

    // op fetched for a step; past the program it reads as the end op
    assign exec_op   = ({1'b0, pc_reg} < op_count_reg) ? op_t'(st_rdata) : '0;
    assign cp_sum    = 17'(cp_reg) + {1'b0, exec_op.data};
    assign cp_wrap   = (cp_sum >= TAPE_SPAN) ? (cp_sum - TAPE_SPAN) : cp_sum;
    assign pc_sum    = {1'b0, pc_reg} + CW'(1);
    assign pc_inc    = (pc_sum == OPS_CNT) ? '0 : pc_sum[PW-1:0];
    assign tgt_sum   = {1'b0, exec_op.data} + 17'd1;
    assign open_tgt  = (tgt_sum == OPS_SPAN) ? '0 : PW'(tgt_sum);

    assign out_free  = !out_full_reg || !res_stall;
    assign clr_last  = (clr_addr_reg == TAPE_END);

    always_comb
    begin
        case (phase_reg)
            PH_FULL:  status = ST_FULL;
            PH_UNBAL: status = ST_UNBAL;
            PH_DEEP:  status = ST_DEEP;
            default:  status = r_early_reg ? ST_EARLY : ST_OK;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EX_CLR_INIT:
            begin
                if (clr_last)
                begin
                    state_next = EX_IDLE;
                end
            end
            EX_IDLE:
            begin
                if (head.valid)
                begin
                    case (kind)
                        CMD_CLEAR:
                            state_next = EX_DONE;
                        CMD_LOAD:
                        begin
                            if ((phase_reg != PH_LOADING)
                                || ((la_reg == LA_OPEN) && (ch == CH_MINUS)))
                            begin
                                state_next = EX_DONE;
                            end
                            else
                            begin
                                state_next = EX_EMIT;
                            end
                        end
                        CMD_FINISH:
                            state_next = (phase_reg == PH_LOADING) ? EX_EMIT : EX_CLR_FIN;
                        CMD_STEP:
                            state_next = (phase_reg == PH_READY) ? EX_FETCH : EX_DONE;
                        default:
                            state_next = EX_DONE;
                    endcase
                end
            end
            EX_EMIT:
            begin
                if (!em_left)
                begin
                    state_next = (kind == CMD_FINISH) ? EX_FIN : EX_DONE;
                end
                else if (close_go)
                begin
                    state_next = EX_CLOSE_RD;
                end
            end
            EX_CLOSE_RD: state_next = EX_CLOSE_WR;
            EX_CLOSE_WR: state_next = EX_EMIT;
            EX_FIN:      state_next = EX_CLR_FIN;
            EX_CLR_FIN:
            begin
                if (clr_last)
                begin
                    state_next = EX_DONE;
                end
            end
            EX_FETCH:    state_next = EX_EXEC;
            EX_EXEC:     state_next = EX_DONE;
            EX_DONE:
            begin
                if (out_free)
                begin
                    state_next = EX_IDLE;
                end
            end
            default:     state_next = EX_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        phase_next     = phase_reg;
        la_next        = la_reg;
        op_count_next  = op_count_reg;
        stack_top_next = stack_top_reg;
        pc_next        = pc_reg;
        cp_next        = cp_reg;
        clr_addr_next  = clr_addr_reg;
        em_n_next      = em_n_reg;
        em_i_next      = em_i_reg;
        em_kind_next   = em_kind_reg;
        em_data_next   = em_data_reg;
        last_next      = last_reg;
        open_next      = open_reg;
        r_byte_next    = r_byte_reg;
        r_ov_next      = r_ov_reg;
        r_taken_next   = r_taken_reg;
        r_early_next   = r_early_reg;
        out_item_next  = out_item_reg;
        out_full_next  = res_stall ? out_full_reg : 1'b0;
        pop            = 1'b0;
        fill_n         = 2'd0;

        st_we    = 1'b0;
        st_waddr = op_count_reg[PW-1:0];
        st_wdata = '0;
        st_raddr = pc_reg;
        tp_we    = 1'b0;
        tp_waddr = cp_reg;
        tp_wdata = 8'h00;
        tp_raddr = cp_reg;
        sk_we    = 1'b0;
        sk_waddr = stack_top_reg[SW-1:0];
        sk_wdata = op_count_reg[PW-1:0];
        sk_raddr = SW'(stack_top_reg - SDW'(1));

        case (state_reg)
            EX_CLR_INIT, EX_CLR_FIN:
            begin
                tp_we         = 1'b1;
                tp_waddr      = clr_addr_reg;
                clr_addr_next = clr_last ? '0 : clr_addr_reg + TW'(1);
            end
            EX_IDLE:
            begin
                if (head.valid)
                begin
                    r_byte_next  = 8'h00;
                    r_ov_next    = 1'b0;
                    r_taken_next = 1'b0;
                    r_early_next = 1'b0;
                    em_i_next    = 2'd0;
                    em_n_next    = 2'd0;
                    case (kind)
                        CMD_CLEAR:
                        begin
                            op_count_next  = '0;
                            stack_top_next = '0;
                            la_next        = LA_NONE;
                            pc_next        = '0;
                            cp_next        = '0;
                            phase_next     = PH_LOADING;
                        end
                        CMD_LOAD:
                        begin
                            if (phase_reg == PH_LOADING)
                            begin
                                if ((la_reg == LA_OPEN) && (ch == CH_MINUS))
                                begin
                                    la_next = LA_OPEN_MINUS;
                                end
                                else if ((la_reg == LA_OPEN_MINUS) && (ch == CH_CLOSE))
                                begin
                                    // "[-]" folds into a clear
                                    la_next         = LA_NONE;
                                    em_kind_next[0] = OP_SET;
                                    em_data_next[0] = 16'h0000;
                                    em_n_next       = 2'd1;
                                end
                                else
                                begin
                                    // flush a pending open first
                                    if (la_reg == LA_OPEN)
                                    begin
                                        em_kind_next[0] = OP_OPEN;
                                        em_data_next[0] = 16'h0000;
                                        fill_n          = 2'd1;
                                    end
                                    else if (la_reg == LA_OPEN_MINUS)
                                    begin
                                        em_kind_next[0] = OP_OPEN;
                                        em_data_next[0] = 16'h0000;
                                        em_kind_next[1] = OP_ADD;
                                        em_data_next[1] = 16'h00FF;
                                        fill_n          = 2'd2;
                                    end
                                    la_next = LA_NONE;
                                    case (ch)
                                        CH_PLUS:
                                        begin
                                            em_kind_next[fill_n] = OP_ADD;
                                            em_data_next[fill_n] = 16'h0001;
                                            fill_n               = fill_n + 2'd1;
                                        end
                                        CH_MINUS:
                                        begin
                                            em_kind_next[fill_n] = OP_ADD;
                                            em_data_next[fill_n] = 16'h00FF;
                                            fill_n               = fill_n + 2'd1;
                                        end
                                        CH_LT:
                                        begin
                                            em_kind_next[fill_n] = OP_PTR;
                                            em_data_next[fill_n] = PTR_BACK;
                                            fill_n               = fill_n + 2'd1;
                                        end
                                        CH_GT:
                                        begin
                                            em_kind_next[fill_n] = OP_PTR;
                                            em_data_next[fill_n] = 16'h0001;
                                            fill_n               = fill_n + 2'd1;
                                        end
                                        CH_DOT:
                                        begin
                                            em_kind_next[fill_n] = OP_PRINT;
                                            em_data_next[fill_n] = 16'h0000;
                                            fill_n               = fill_n + 2'd1;
                                        end
                                        CH_COMMA:
                                        begin
                                            em_kind_next[fill_n] = OP_READ;
                                            em_data_next[fill_n] = 16'h0000;
                                            fill_n               = fill_n + 2'd1;
                                        end
                                        CH_CLOSE:
                                        begin
                                            em_kind_next[fill_n] = OP_CLOSE;
                                            em_data_next[fill_n] = 16'h0000;
                                            fill_n               = fill_n + 2'd1;
                                        end
                                        CH_OPEN:
                                            la_next = LA_OPEN;
                                        default:
                                        begin
                                        end
                                    endcase
                                    em_n_next = fill_n;
                                end
                            end
                        end
                        CMD_FINISH:
                        begin
                            if (phase_reg == PH_LOADING)
                            begin
                                if (la_reg == LA_OPEN)
                                begin
                                    em_kind_next[0] = OP_OPEN;
                                    em_data_next[0] = 16'h0000;
                                    em_n_next       = 2'd1;
                                end
                                else if (la_reg == LA_OPEN_MINUS)
                                begin
                                    em_kind_next[0] = OP_OPEN;
                                    em_data_next[0] = 16'h0000;
                                    em_kind_next[1] = OP_ADD;
                                    em_data_next[1] = 16'h00FF;
                                    em_n_next       = 2'd2;
                                end
                                la_next = LA_NONE;
                            end
                            else
                            begin
                                if (phase_reg == PH_HALTED)
                                begin
                                    phase_next = PH_READY;
                                end
                                pc_next = '0;
                                cp_next = '0;
                            end
                        end
                        CMD_STEP:
                        begin
                            if (phase_reg == PH_LOADING)
                            begin
                                r_early_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            EX_EMIT:
            begin
                if (em_live)
                begin
                    if (merge_add)
                    begin
                        last_next.data = {8'h00, last_reg.data[7:0] + cur_data[7:0]};
                        st_we          = 1'b1;
                        st_waddr       = PW'(op_count_reg - CW'(1));
                        st_wdata       = last_next;
                        em_i_next      = em_i_reg + 2'd1;
                    end
                    else if (merge_ptr)
                    begin
                        last_next.data = ptr_wrap[15:0];
                        st_we          = 1'b1;
                        st_waddr       = PW'(op_count_reg - CW'(1));
                        st_wdata       = last_next;
                        em_i_next      = em_i_reg + 2'd1;
                    end
                    else if (no_room)
                    begin
                        phase_next = PH_FULL;
                        em_i_next  = em_i_reg + 2'd1;
                    end
                    else
                    begin
                        case (cur_kind)
                            OP_OPEN:
                            begin
                                if (stack_top_reg >= STACK_CAP)
                                begin
                                    phase_next = PH_DEEP;
                                end
                                else
                                begin
                                    sk_we          = 1'b1;
                                    st_we          = 1'b1;
                                    st_wdata       = '{kind: OP_OPEN, data: 16'h0000};
                                    last_next      = st_wdata;
                                    stack_top_next = stack_top_reg + SDW'(1);
                                    op_count_next  = op_count_reg + CW'(1);
                                end
                                em_i_next = em_i_reg + 2'd1;
                            end
                            OP_CLOSE:
                            begin
                                if (stack_top_reg == '0)
                                begin
                                    phase_next = PH_UNBAL;
                                    em_i_next  = em_i_reg + 2'd1;
                                end
                                else
                                begin
                                    // pop; the matching open arrives next cycle
                                    stack_top_next = stack_top_reg - SDW'(1);
                                end
                            end
                            default:
                            begin
                                st_we         = 1'b1;
                                st_wdata      = '{kind: cur_kind, data: cur_data};
                                last_next     = st_wdata;
                                op_count_next = op_count_reg + CW'(1);
                                em_i_next     = em_i_reg + 2'd1;
                            end
                        endcase
                    end
                end
                else if (em_left)
                begin
                    em_i_next = em_i_reg + 2'd1;
                end
            end
            EX_CLOSE_RD:
            begin
                // patch the open with the index of its close
                open_next = sk_rdata;
                st_we     = 1'b1;
                st_waddr  = sk_rdata;
                st_wdata  = '{kind: OP_OPEN, data: 16'(op_count_reg)};
            end
            EX_CLOSE_WR:
            begin
                st_we         = 1'b1;
                st_wdata      = '{kind: OP_CLOSE, data: 16'(open_reg)};
                last_next     = st_wdata;
                op_count_next = op_count_reg + CW'(1);
                em_i_next     = em_i_reg + 2'd1;
            end
            EX_FIN:
            begin
                if (phase_reg == PH_LOADING)
                begin
                    if (stack_top_reg != '0)
                    begin
                        phase_next = PH_UNBAL;
                    end
                    else
                    begin
                        st_we         = 1'b1;
                        st_wdata      = '{kind: OP_END, data: 16'h0000};
                        op_count_next = op_count_reg + CW'(1);
                        phase_next    = PH_READY;
                    end
                end
                pc_next = '0;
                cp_next = '0;
            end
            EX_EXEC:
            begin
                pc_next = pc_inc;
                case (exec_op.kind)
                    OP_END:
                    begin
                        phase_next = PH_HALTED;
                        pc_next    = pc_reg;
                    end
                    OP_SET:
                    begin
                        tp_we    = 1'b1;
                        tp_wdata = exec_op.data[7:0];
                    end
                    OP_ADD:
                    begin
                        tp_we    = 1'b1;
                        tp_wdata = tp_rdata + exec_op.data[7:0];
                    end
                    OP_PTR:
                        cp_next = TW'(cp_wrap);
                    OP_PRINT:
                    begin
                        r_byte_next = tp_rdata;
                        r_ov_next   = 1'b1;
                    end
                    OP_READ:
                    begin
                        if (head.entry.item.in_valid)
                        begin
                            tp_we        = 1'b1;
                            tp_wdata     = head.entry.item.in_byte;
                            r_taken_next = 1'b1;
                        end
                    end
                    OP_OPEN:
                    begin
                        if (tp_rdata == 8'h00)
                        begin
                            pc_next = open_tgt;
                        end
                    end
                    OP_CLOSE:
                        pc_next = PW'(exec_op.data);
                    default:
                    begin
                    end
                endcase
            end
            EX_DONE:
            begin
                if (out_free)
                begin
                    out_item_next.out_byte  = r_byte_reg;
                    out_item_next.out_valid = r_ov_reg;
                    out_item_next.in_taken  = r_taken_reg;
                    out_item_next.halted    = (phase_reg == PH_HALTED);
                    out_item_next.status    = status;
                    out_full_next           = 1'b1;
                    pop                     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EX_CLR_INIT;
            phase_reg     <= PH_LOADING;
            la_reg        <= LA_NONE;
            op_count_reg  <= '0;
            stack_top_reg <= '0;
            pc_reg        <= '0;
            cp_reg        <= '0;
            clr_addr_reg  <= '0;
            em_n_reg      <= 2'd0;
            em_i_reg      <= 2'd0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            la_reg        <= la_next;
            op_count_reg  <= op_count_next;
            stack_top_reg <= stack_top_next;
            pc_reg        <= pc_next;
            cp_reg        <= cp_next;
            clr_addr_reg  <= clr_addr_next;
            em_n_reg      <= em_n_next;
            em_i_reg      <= em_i_next;
            out_full_reg  <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        em_kind_reg  <= em_kind_next;
        em_data_reg  <= em_data_next;
        last_reg     <= last_next;
        open_reg     <= open_next;
        r_byte_reg   <= r_byte_next;
        r_ov_reg     <= r_ov_next;
        r_taken_reg  <= r_taken_next;
        r_early_reg  <= r_early_next;
        out_item_reg <= out_item_next;
    end

    assign res_valid = out_full_reg;
    assign res_item  = out_item_reg;

endmodule

// ===== rtl/bf_op_folding_machine_unit.sv =====
// Top level of the folding op machine: command queue front end and executor.
// Depends on bfom_pkg, bfom_front, bfom_exec and bfom_ram.
//
//  channel | payload    | handshake           | direction
//  --------+------------+---------------------+----------
//  command | cmd_item   | cmd_valid/cmd_stall | in
//  result  | res_item   | res_valid/res_stall | out
//
// One result transfer follows every command transfer, in order.
// Steps per command: clear is dispatched and then answered; load takes dispatch,
// one step per op written or merged, one to wrap up and the result, and a
// close bracket adds the CLOSE_RD and CLOSE_WR states; step reads the op store
// and tape, then writes the tape; finish zeroes the tape one cell a cycle.
// A stalled result holds the next result back. After reset the tape is zeroed
// before the first command leaves the queue; commands still transfer into it.
// A two entry queue and the result register let either side stall on its own.
module bf_op_folding_machine_unit
    import bfom_pkg::*;
#(
    parameter int PROG_OPS   = 4096,
    parameter int TAPE_CELLS = 32768,
    parameter int NEST_DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_item,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    queue_head_t head;
    logic        pop;

    // accept and classify commands
    bfom_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .head      (head),
        .pop       (pop)
    );

    // compile, run and hold the result until it is taken
    bfom_exec #(
        .PROG_OPS   (PROG_OPS),
        .TAPE_CELLS (TAPE_CELLS),
        .NEST_DEPTH (NEST_DEPTH)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
